### design/pdir_pkg.sv
package pdir_pkg;

  // Default time-difference width and field widths
  localparam int TimeBitsDef = 16;
  localparam int CfgW        = 16;
  localparam int WdW         = 10;
  localparam int CfgIdxW     = 3;

  // Result queue geometry
  localparam int ResDepth = 4;
  localparam int ResPtrW  = $clog2(ResDepth);
  localparam int ResCntW  = $clog2(ResDepth + 1);

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_START_MIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_MAX   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STOP_MIN    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ONE_GAP_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WD_LIMIT    = 3'd4;

  // Register reset values
  localparam logic [CfgW-1:0] START_MIN_RST   = 16'd500;
  localparam logic [CfgW-1:0] START_MAX_RST   = 16'd750;
  localparam logic [CfgW-1:0] STOP_MIN_RST    = 16'd800;
  localparam logic [CfgW-1:0] ONE_GAP_MAX_RST = 16'd200;
  localparam logic [WdW-1:0]  WD_LIMIT_RST    = 10'd651;

  // Full byte bit count
  localparam logic [3:0] FULL_BITS = 4'd8;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  // Edge pairing: no edge yet, inside a pulse, inside a gap
  typedef enum logic [2:0] {
    PH_NONE  = 3'b001,
    PH_PULSE = 3'b010,
    PH_GAP   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [CfgW-1:0] start_min;
    logic [CfgW-1:0] start_max;
    logic [CfgW-1:0] stop_min;
    logic [CfgW-1:0] one_gap_max;
    logic [WdW-1:0]  wd_limit;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [3:0] valid_bits;
    logic       last;
  } result_t;

  // Up to two results per request, first one in r0
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

### design/pdir_decoder.sv
module pdir_decoder import pdir_pkg::*; #(
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  op_e         operation_i,
  input  logic [15:0] timestamp_i,
  input  cfg_t        cfg_i,
  output push_t       push_o
);

  localparam int CmpW = (TIME_BITS > CfgW) ? TIME_BITS : CfgW;

  logic                 rx_q, rx_d;
  phase_e               phase_q, phase_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic                 wd_run_q, wd_run_d;
  logic [WdW-1:0]       wd_cnt_q, wd_cnt_d;
  logic [2:0]           bitpos_q, bitpos_d;
  logic [7:0]           shift_q, shift_d;

  logic [TIME_BITS-1:0] ts_w, delta_w;
  logic [CmpW-1:0]      delta_x;
  logic [WdW-1:0]       wd_inc;
  logic [7:0]           shift_set;
  logic                 is_start, is_stop;
  push_t                push;

  assign ts_w    = TIME_BITS'(timestamp_i);
  assign delta_w = ts_w - last_q;
  assign delta_x = CmpW'(delta_w);
  assign wd_inc  = wd_cnt_q + WdW'(1);

  assign is_start = !rx_q && (delta_x >= CmpW'(cfg_i.start_min))
                          && (delta_x <= CmpW'(cfg_i.start_max));
  assign is_stop  = rx_q && (delta_x >= CmpW'(cfg_i.stop_min));

  // gap at or below threshold decodes as one
  assign shift_set = (delta_x <= CmpW'(cfg_i.one_gap_max)) ?
                     (shift_q | (8'h80 >> bitpos_q)) : shift_q;

  always_comb begin
    rx_d     = rx_q;
    phase_d  = phase_q;
    last_d   = last_q;
    wd_run_d = wd_run_q;
    wd_cnt_d = wd_cnt_q;
    bitpos_d = bitpos_q;
    shift_d  = shift_q;
    push     = '0;
    push.r0.kind = KIND_DATA;
    push.r1.kind = KIND_DATA;

    if (take_i) begin
      if (operation_i == OP_TICK) begin
        if (wd_run_q) begin
          if (wd_inc >= cfg_i.wd_limit) begin
            wd_run_d = 1'b0;
            wd_cnt_d = '0;
            rx_d     = 1'b0;
            phase_d  = PH_NONE;
            bitpos_d = '0;
            shift_d  = '0;
            if (rx_q) begin
              push.v0      = 1'b1;
              push.r0.kind = KIND_DROP;
              push.r0.last = 1'b1;
            end
          end else begin
            wd_cnt_d = wd_inc;
          end
        end
      end else begin
        last_d = ts_w;
        case (phase_q)
          PH_NONE: begin
            phase_d = PH_PULSE;
          end
          PH_PULSE: begin
            phase_d = PH_GAP;
            if (is_start) begin
              rx_d     = 1'b1;
              wd_run_d = 1'b1;
              wd_cnt_d = '0;
            end else if (is_stop) begin
              wd_run_d = 1'b0;
              wd_cnt_d = '0;
              rx_d     = 1'b0;
              phase_d  = PH_NONE;
              bitpos_d = '0;
              shift_d  = '0;
              if (bitpos_q != 3'd0) begin
                // partial byte first, then frame end
                push.v0            = 1'b1;
                push.r0.kind       = KIND_DATA;
                push.r0.data_byte  = shift_q;
                push.r0.valid_bits = {1'b0, bitpos_q};
                push.v1            = 1'b1;
                push.r1.kind       = KIND_END;
                push.r1.last       = 1'b1;
              end else begin
                push.v0      = 1'b1;
                push.r0.kind = KIND_END;
                push.r0.last = 1'b1;
              end
            end else begin
              wd_run_d = 1'b1;
              wd_cnt_d = '0;
            end
          end
          PH_GAP: begin
            phase_d  = PH_PULSE;
            wd_run_d = 1'b0;
            if (rx_q) begin
              if (bitpos_q == 3'd7) begin
                push.v0            = 1'b1;
                push.r0.kind       = KIND_DATA;
                push.r0.data_byte  = shift_set;
                push.r0.valid_bits = FULL_BITS;
                push.r0.last       = 1'b1;
                bitpos_d           = '0;
                shift_d            = '0;
              end else begin
                bitpos_d = bitpos_q + 3'd1;
                shift_d  = shift_set;
              end
            end
          end
          default: begin
            phase_d = PH_NONE;
          end
        endcase
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q     <= 1'b0;
      phase_q  <= PH_NONE;
      last_q   <= '0;
      wd_run_q <= 1'b0;
      wd_cnt_q <= '0;
      bitpos_q <= '0;
      shift_q  <= '0;
    end else begin
      rx_q     <= rx_d;
      phase_q  <= phase_d;
      last_q   <= last_d;
      wd_run_q <= wd_run_d;
      wd_cnt_q <= wd_cnt_d;
      bitpos_q <= bitpos_d;
      shift_q  <= shift_d;
    end
  end

  // receiving always follows a start pulse, so pairing is never cleared then
  a_rx_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_q |-> (phase_q != PH_NONE))
    else $error("receiving with edge pairing cleared");

  // a second result only ever follows a partial byte and is the frame end
  a_second_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.v1 |-> (push.v0 && push.r1.kind == KIND_END && push.r1.last
                 && !push.r0.last))
    else $error("bad second result");

endmodule

### design/pdir_result_fifo.sv
module pdir_result_fifo import pdir_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t head_o
);

  result_t              mem_q [ResDepth];
  logic [ResPtrW-1:0]   wr_q, rd_q;
  logic [ResCntW-1:0]   cnt_q, cnt_d;
  logic                 pop;
  logic [ResCntW-1:0]   push_n;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign push_n  = ResCntW'(push_i.v0) + ResCntW'(push_i.v1);
  // room for two results is needed before taking a request
  assign full_o  = (cnt_q > ResCntW'(ResDepth - 2));
  assign cnt_d   = cnt_q + push_n - ResCntW'(pop);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wr_q] <= push_i.r0;
    if (push_i.v1) mem_q[wr_q + ResPtrW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + ResPtrW'(push_n);
      rd_q  <= rd_q + ResPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != '0) |-> (cnt_q <= ResCntW'(ResDepth - 2)))
    else $error("result queue overflow");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(ResDepth))
    else $error("result count out of range");

endmodule

### design/pulse_distance_ir_receiver_unit.sv
// Pulse-distance optical frame receiver.
// Input channel (in_valid_i / in_stall_o): one request per receive-line edge
// (operation_i = edge, timestamp_i = edge time) or per timebase tick.
// Output channel (out_valid_o / out_stall_i): results of kind data byte,
// frame end or frame dropped; last_o marks the final result of a request.
// A request is decoded in the cycle it is taken; its results are registered
// into a four-entry result queue, whose head drives the output.
// Throughput: one request per cycle while the output drains. A stop pulse
// with a partial byte yields two results, which leave the output in turn.
// in_stall_o rises when the queue holds fewer than two free entries, so an
// output stall backs up to the input once three or four results are queued.
// Config writes (cfg_we_i, cfg_index_i, cfg_wdata_i) are registered;
// indexes past the watchdog limit are ignored. Write only while idle.
// Reset empties the queue, returns the receiver to idle with edge pairing
// cleared and watchdog stopped, and loads the default timing windows.
module pulse_distance_ir_receiver_unit import pdir_pkg::*; #(
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [15:0]        timestamp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         data_byte_o,
  output logic [3:0]         valid_bits_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t    cfg_q;
  push_t   push;
  result_t head;
  logic    full;
  logic    take;

  // request taken when valid and not stalled
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  // timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_min   <= START_MIN_RST;
      cfg_q.start_max   <= START_MAX_RST;
      cfg_q.stop_min    <= STOP_MIN_RST;
      cfg_q.one_gap_max <= ONE_GAP_MAX_RST;
      cfg_q.wd_limit    <= WD_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_MIN:   cfg_q.start_min   <= cfg_wdata_i;
        CFG_START_MAX:   cfg_q.start_max   <= cfg_wdata_i;
        CFG_STOP_MIN:    cfg_q.stop_min    <= cfg_wdata_i;
        CFG_ONE_GAP_MAX: cfg_q.one_gap_max <= cfg_wdata_i;
        CFG_WD_LIMIT:    cfg_q.wd_limit    <= cfg_wdata_i[WdW-1:0];
        default: ;
      endcase
    end
  end

  // edge pairing, bit decode and watchdog
  pdir_decoder #(
    .TIME_BITS(TIME_BITS)
  ) u_decoder (
    .clk_i,
    .rst_ni,
    .take_i      (take),
    .operation_i (op_e'(operation_i)),
    .timestamp_i,
    .cfg_i       (cfg_q),
    .push_o      (push)
  );

  // result queue, parts the input from output stalls
  pdir_result_fifo u_result_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign kind_o       = head.kind;
  assign data_byte_o  = head.data_byte;
  assign valid_bits_o = head.valid_bits;
  assign last_o       = head.last;

endmodule
